// File: sv/lfu_pkg.sv
// Shared types and constants for the LFU cache table.
`default_nettype none
package lfu_pkg;

   // Fixed field widths and upper bounds of the sized parameters
   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int CSR_W     = 5;
   localparam int IDX_MAX_W = 8;
   localparam int CNT_MAX_W = 32;

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic                      mode;
      logic        [KEY_W-1:0]   key;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [VALUE_W-1:0] read_value;
      logic                      evicted;
   } rsp_type;

   // Update broadcast to every cell
   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_TOUCH   = 2'd1,
      OP_INSERT  = 2'd2,
      OP_REPLACE = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic                   put;
      logic [IDX_MAX_W-1:0]   idx;
      logic [IDX_MAX_W-1:0]   rank;
      logic [KEY_W-1:0]       key;
      logic [VALUE_W-1:0]     value;
   } cmd_type;

   // Search token handed from cell to cell
   typedef struct packed {
      logic                   found;
      logic [IDX_MAX_W-1:0]   found_idx;
      logic [IDX_MAX_W-1:0]   found_rank;
      logic [VALUE_W-1:0]     found_value;
      logic                   free_found;
      logic [IDX_MAX_W-1:0]   free_idx;
      logic                   best_valid;
      logic [CNT_MAX_W-1:0]   best_count;
      logic [IDX_MAX_W-1:0]   best_rank;
      logic [IDX_MAX_W-1:0]   best_idx;
   } token_type;

endpackage
`default_nettype wire

// File: sv/lfu_cell.sv
// One cache entry: holds key, value, use count and recency rank, and folds itself into the search token.
`default_nettype none
module lfu_cell #(
   parameter int ID         = 0,
   parameter int INDEX_W    = 4,
   parameter int COUNT_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [31:0]        key_in,
   input  wire lfu_pkg::token_type tok_in,
   output lfu_pkg::token_type      tok_out,
   input  wire lfu_pkg::cmd_type   cmd
);
   import lfu_pkg::*;

   localparam logic [INDEX_W-1:0] MY_ID = INDEX_W'(ID);

   logic                  valid_ff, valid_in;
   logic [KEY_W-1:0]      key_ff, key_in_nxt;
   logic [VALUE_W-1:0]    value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [INDEX_W-1:0]    rank_ff, rank_in;
   token_type             tok_ff, tok_in_nxt;

   logic match, better, is_me, newer;

   // Fold this entry into the passing search token
   always_comb begin
      match      = valid_ff && (key_ff == key_in);
      better     = valid_ff && (!tok_in.best_valid ||
                   (CNT_MAX_W'(count_ff) < tok_in.best_count) ||
                   ((CNT_MAX_W'(count_ff) == tok_in.best_count) &&
                    (IDX_MAX_W'(rank_ff) > tok_in.best_rank)));
      tok_in_nxt = tok_in;
      if (match && !tok_in.found) begin
         tok_in_nxt.found       = 1'b1;
         tok_in_nxt.found_idx   = IDX_MAX_W'(MY_ID);
         tok_in_nxt.found_rank  = IDX_MAX_W'(rank_ff);
         tok_in_nxt.found_value = value_ff;
      end
      if (!valid_ff && !tok_in.free_found) begin
         tok_in_nxt.free_found = 1'b1;
         tok_in_nxt.free_idx   = IDX_MAX_W'(MY_ID);
      end
      if (better) begin
         tok_in_nxt.best_valid = 1'b1;
         tok_in_nxt.best_count = CNT_MAX_W'(count_ff);
         tok_in_nxt.best_rank  = IDX_MAX_W'(rank_ff);
         tok_in_nxt.best_idx   = IDX_MAX_W'(MY_ID);
      end
   end

   // Apply the broadcast update
   always_comb begin
      is_me      = (cmd.idx[INDEX_W-1:0] == MY_ID);
      newer      = valid_ff && (rank_ff < cmd.rank[INDEX_W-1:0]);
      valid_in   = valid_ff;
      key_in_nxt = key_ff;
      value_in   = value_ff;
      count_in   = count_ff;
      rank_in    = rank_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_TOUCH: begin
            if (is_me) begin
               if (count_ff != {COUNT_BITS{1'b1}}) count_in = count_ff + 1'b1;
               rank_in = '0;
               if (cmd.put) value_in = cmd.value;
            end else if (newer) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_INSERT: begin
            if (is_me) begin
               valid_in   = 1'b1;
               key_in_nxt = cmd.key;
               value_in   = cmd.value;
               count_in   = COUNT_BITS'(1);
               rank_in    = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         OP_REPLACE: begin
            if (is_me) begin
               key_in_nxt = cmd.key;
               value_in   = cmd.value;
               count_in   = COUNT_BITS'(1);
               rank_in    = '0;
            end else if (newer) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      key_ff   <= key_in_nxt;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
      tok_ff   <= tok_in_nxt;
   end

   assign tok_out = tok_ff;

endmodule
`default_nettype wire

// File: sv/lfu_cache_table.sv
// LFU cache table top level: a chain of entry cells with a search token and an update sequencer.
// The response follows once the search token has walked the whole cell chain (token walks one cell per cycle).
// The next request is taken only after the token walk down the cell chain and the update have finished.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous): all entries invalid, occupancy zero, capacity 16.
`default_nettype none
module lfu_cache_table #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire lfu_pkg::req_type             req_data,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output lfu_pkg::rsp_type                  rsp_data,
   input  wire logic                         csr_we,
   input  wire logic [lfu_pkg::CSR_W-1:0]    csr_wdata
);
   import lfu_pkg::*;

   localparam int INDEX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OCC_W   = $clog2(ENTRIES + 1);
   localparam int CAP_W   = (OCC_W > CSR_W) ? OCC_W : CSR_W;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_UPDATE = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CSR_W-1:0]   cap_ff;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   scan_ff, scan_in;
   req_type            req_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cmd_type            cmd;
   token_type          tok_w [0:ENTRIES];
   token_type          tok_end;
   logic [CAP_W-1:0]   cap_eff;
   logic               out_free;

   // Empty token enters the head of the chain
   assign tok_w[0] = '0;
   assign tok_end  = tok_w[ENTRIES];

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lfu_cell #(
         .ID        (i),
         .INDEX_W   (INDEX_W),
         .COUNT_BITS(COUNT_BITS)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .key_in (req_ff.key),
         .tok_in (tok_w[i]),
         .tok_out(tok_w[i+1]),
         .cmd    (cmd)
      );
   end

   assign cap_eff  = (CAP_W'(cap_ff) > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : CAP_W'(cap_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequence: take request, walk token, decide and broadcast update
   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      occ_in       = occ_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.op       = OP_NONE;
      cmd.key      = req_ff.key;
      cmd.value    = req_ff.value;
      cmd.put      = (req_ff.mode == MODE_PUT);
      req_ready    = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_SCAN;
               scan_in  = '0;
            end
         end
         S_SCAN: begin
            scan_in = scan_ff + 1'b1;
            if (scan_ff == OCC_W'(ENTRIES - 1)) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               if (req_ff.mode == MODE_GET) begin
                  if (tok_end.found) begin
                     cmd.op            = OP_TOUCH;
                     cmd.idx           = tok_end.found_idx;
                     cmd.rank          = tok_end.found_rank;
                     rsp_in.hit        = 1'b1;
                     rsp_in.read_value = tok_end.found_value;
                  end
               end else if (cap_eff != '0) begin
                  if (tok_end.found) begin
                     cmd.op     = OP_TOUCH;
                     cmd.idx    = tok_end.found_idx;
                     cmd.rank   = tok_end.found_rank;
                     rsp_in.hit = 1'b1;
                  end else if (CAP_W'(occ_ff) < cap_eff) begin
                     cmd.op  = OP_INSERT;
                     cmd.idx = tok_end.free_idx;
                     occ_in  = occ_ff + 1'b1;
                  end else if (tok_end.best_valid) begin
                     cmd.op         = OP_REPLACE;
                     cmd.idx        = tok_end.best_idx;
                     cmd.rank       = tok_end.best_rank;
                     rsp_in.evicted = 1'b1;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cap_ff       <= CSR_W'(16);
         occ_ff       <= '0;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) cap_ff <= csr_wdata;
      end
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the LFU cache table: directed table, then random traffic.
`default_nettype none
module tb_top;
   import lfu_pkg::*;

   localparam int NUM_ENTRIES = 16;
   localparam int COUNT_MAX   = 65535;
   localparam int DRAIN_WAIT  = 40;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_W-1:0] csr_wdata = '0;

   lfu_cache_table DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // Shadow copy of the table
   int unsigned   cap_reg;
   bit            sh_valid [NUM_ENTRIES];
   bit [31:0]     sh_key   [NUM_ENTRIES];
   bit [31:0]     sh_value [NUM_ENTRIES];
   int unsigned   sh_count [NUM_ENTRIES];
   int unsigned   sh_rank  [NUM_ENTRIES];
   int unsigned   sh_fill;

   rsp_type   pending_rsp[$];
   int        fail_count = 0;
   int        send_idle = 0;
   int        recv_stall = 0;
   int        key_pool_size = 8;

   // Age entries newer than slot s and make s the newest
   function automatic void promote(int s);
      int j;
      for (j = 0; j < NUM_ENTRIES; j++)
         if (sh_valid[j] && j != s && sh_rank[j] < sh_rank[s]) sh_rank[j]++;
      sh_rank[s] = 0;
   endfunction

   function automatic rsp_type lfu_access(req_type rq);
      rsp_type r;
      int j, found, slot, vic;
      int unsigned cap_eff;
      r = '0;
      found = -1;
      cap_eff = (cap_reg > NUM_ENTRIES) ? NUM_ENTRIES : cap_reg;
      for (j = 0; j < NUM_ENTRIES; j++)
         if (found < 0 && sh_valid[j] && sh_key[j] == rq.key) found = j;
      if (rq.mode == MODE_GET) begin
         if (found >= 0) begin
            r.hit = 1'b1;
            r.read_value = sh_value[found];
            if (sh_count[found] < COUNT_MAX) sh_count[found]++;
            promote(found);
         end
      end else if (cap_eff != 0) begin
         if (found >= 0) begin
            r.hit = 1'b1;
            sh_value[found] = rq.value;
            if (sh_count[found] < COUNT_MAX) sh_count[found]++;
            promote(found);
         end else if (sh_fill < cap_eff) begin
            slot = -1;
            for (j = 0; j < NUM_ENTRIES; j++)
               if (slot < 0 && !sh_valid[j]) slot = j;
            for (j = 0; j < NUM_ENTRIES; j++)
               if (sh_valid[j]) sh_rank[j]++;
            sh_valid[slot] = 1'b1;
            sh_key[slot] = rq.key;
            sh_value[slot] = rq.value;
            sh_count[slot] = 1;
            sh_rank[slot] = 0;
            sh_fill++;
         end else begin
            vic = -1;
            for (j = 0; j < NUM_ENTRIES; j++)
               if (sh_valid[j] && (vic < 0 || sh_count[j] < sh_count[vic] ||
                   (sh_count[j] == sh_count[vic] && sh_rank[j] > sh_rank[vic])))
                  vic = j;
            if (vic >= 0) begin
               r.evicted = 1'b1;
               sh_key[vic] = rq.key;
               sh_value[vic] = rq.value;
               sh_count[vic] = 1;
               promote(vic);
            end
         end
      end
      return r;
   endfunction

   // Send one transaction, honoring the sender idle ratio
   task automatic send_req(req_type rq, bit has_exp, rsp_type exp_rsp);
      rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p = lfu_access(rq);
      pending_rsp.push_back(has_exp ? exp_rsp : p);
      req_valid <= 1'b1;
      req_data  <= rq;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_capacity(int unsigned c);
      csr_we    <= 1'b1;
      csr_wdata <= c[CSR_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      cap_reg = c;
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Receiver: stall at random, check each transaction in order
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.read_value !== want.read_value ||
                   rsp_data.evicted !== want.evicted) begin
                  $display("%0t mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   typedef struct {
      bit      mode;
      bit [31:0] key;
      bit [31:0] value;
      bit      has_exp;
      bit      e_hit;
      bit [31:0] e_rd;
      bit      e_ev;
   } stim_row;

   stim_row dir_rows[] = '{
      '{MODE_GET, 32'h0,        32'h0,        1, 0, 32'h0,        0}, // empty table
      '{MODE_PUT, 32'h0,        32'h7FFFFFFF, 1, 0, 32'h0,        0},
      '{MODE_PUT, 32'hFFFFFFFF, 32'h80000000, 1, 0, 32'h0,        0},
      '{MODE_GET, 32'h0,        32'h0,        1, 1, 32'h7FFFFFFF, 0},
      '{MODE_GET, 32'hFFFFFFFF, 32'h12345678, 1, 1, 32'h80000000, 0},
      '{MODE_PUT, 32'h0,        32'hFFFFFFFF, 1, 1, 32'h0,        0}, // update
      '{MODE_GET, 32'h0,        32'h0,        1, 1, 32'hFFFFFFFF, 0},
      '{MODE_GET, 32'h55555555, 32'h0,        1, 0, 32'h0,        0}, // miss
      '{MODE_PUT, 32'hAAAAAAAA, 32'h55555555, 0, 0, 32'h0,        0},
      '{MODE_PUT, 32'h55555555, 32'hAAAAAAAA, 0, 0, 32'h0,        0},
      '{MODE_GET, 32'hAAAAAAAA, 32'h0,        0, 0, 32'h0,        0},
      '{MODE_GET, 32'h55555555, 32'h0,        0, 0, 32'h0,        0}
   };

   function automatic bit [31:0] pick_key();
      if ($urandom_range(9) == 0) return $urandom();
      return $urandom_range(key_pool_size - 1) * 32'h01010101 + 32'hF0000000;
   endfunction

   initial begin
      req_type rq;
      rsp_type ex;
      int i, ph, n;
      int unsigned caps[6] = '{16, 1, 0, 31, 4, 16};
      cap_reg = 16;
      sh_fill = 0;
      for (i = 0; i < NUM_ENTRIES; i++) begin
         sh_valid[i] = 0; sh_key[i] = 0; sh_value[i] = 0; sh_count[i] = 0; sh_rank[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      foreach (dir_rows[i]) begin
         rq.mode = dir_rows[i].mode; rq.key = dir_rows[i].key; rq.value = dir_rows[i].value;
         ex.hit = dir_rows[i].e_hit; ex.read_value = dir_rows[i].e_rd;
         ex.evicted = dir_rows[i].e_ev;
         send_req(rq, dir_rows[i].has_exp, ex);
      end
      // Fill past capacity so the tie-break and eviction run
      for (i = 0; i < 20; i++) begin
         rq.mode = MODE_PUT; rq.key = 32'h100 + i; rq.value = i;
         send_req(rq, 0, ex);
      end
      drain();

      // Random phases across idling patterns and capacity settings
      for (ph = 0; ph < 12; ph++) begin
         drain();
         write_capacity(caps[ph % 6]);
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 50; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 50; end
            default: begin send_idle = 25; recv_stall = 25; end
         endcase
         key_pool_size = (ph % 3 == 0) ? 6 : ((ph % 3 == 1) ? 20 : 40);
         for (n = 0; n < 140; n++) begin
            rq.mode  = $urandom_range(1);
            rq.key   = pick_key();
            rq.value = $urandom();
            send_req(rq, 0, ex);
         end
      end
      // Capacity lowered below occupancy
      drain();
      write_capacity(2);
      for (n = 0; n < 40; n++) begin
         rq.mode = $urandom_range(1); rq.key = pick_key(); rq.value = $urandom();
         send_req(rq, 0, ex);
      end
      drain();
      if (fail_count == 0)
         $display("[lfu_cache_table] OK");
      else
         $display("[lfu_cache_table] ERROR");
      $finish;
   end

   initial begin
      #2000000;
      $display("[lfu_cache_table] ERROR");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
sv/lfu_pkg.sv
sv/lfu_cell.sv
sv/lfu_cache_table.sv
tb/tb_top.sv
